// ===== src/alm_pkg.sv =====
package alm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] MIN_ID = 32'd1000;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_INSERT = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [1:0] TK_ONESHOT = 2'd0;
    localparam logic [1:0] TK_PERIODIC = 2'd1;
    localparam logic [1:0] TK_WEEKLY = 2'd2;
    localparam logic [1:0] TK_UNUSED = 2'd3;

    localparam logic [1:0] ACT_ON = 2'd0;
    localparam logic [1:0] ACT_OFF = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [2:0] RK_FIRED = 3'd0;
    localparam logic [2:0] RK_DONE = 3'd1;
    localparam logic [2:0] RK_INSERTED = 3'd2;
    localparam logic [2:0] RK_REJECTED = 3'd3;
    localparam logic [2:0] RK_DELETED = 3'd4;
    localparam logic [2:0] RK_NOT_FOUND = 3'd5;
    localparam logic [2:0] RK_FULL = 3'd6;

    localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_INSERT,
        OP_DELETE,
        OP_REJECT
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIND,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] alarm_id;
        logic [1:0]  timer_kind;
        logic [1:0]  action;
        logic [31:0] time_value;
        logic [6:0]  weekday_mask;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] alarm_id_res;
        logic [1:0]  fired_action;
        logic        removed;
        logic        switch_on;
        logic        pin_level;
        logic [4:0]  entry_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic     valid;
        op_t      op;
        in_word_t word;
    } q_head_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [1:0]  kind;
        logic [1:0]  action;
        logic [31:0] tval;
        logic [31:0] mark;
        logic [6:0]  days;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } entry_t;

    function automatic logic apply_act(input logic sw, input logic [1:0] act);
        logic r;
        r = sw;
        case (act)
            ACT_ON: r = 1'b1;
            ACT_OFF: r = 1'b0;
            ACT_TOGGLE: r = ~sw;
            default: r = sw;
        endcase
        return r;
    endfunction

endpackage

// ===== src/alm_front.sv =====
module alm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  alm_pkg::in_word_t in_data,
    output alm_pkg::q_head_t  head,
    input  logic              pop
);
    import alm_pkg::*;

    q_head_t    q_reg [2];
    q_head_t    item;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    // Static checks are done here; the one-shot time check needs the live timestamp.
    always_comb
    begin
        item.valid = 1'b1;
        item.word = in_data;
        case (in_data.func)
            FN_TICK: item.op = OP_TICK;
            FN_DELETE: item.op = OP_DELETE;
            FN_INSERT:
            begin
                if (in_data.alarm_id < MIN_ID || in_data.timer_kind == TK_UNUSED ||
                    (in_data.timer_kind == TK_WEEKLY && in_data.weekday_mask == 7'd0))
                    item.op = OP_REJECT;
                else
                    item.op = OP_INSERT;
            end
            default: item.op = OP_REJECT;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;

    always_comb
    begin
        head = q_reg[rd_ptr_reg];
        head.valid = (cnt_reg != 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/alm_back.sv =====
module alm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  alm_pkg::q_head_t   head,
    output logic               pop,
    input  logic               level,
    output logic               out_valid,
    input  logic               out_ready,
    output alm_pkg::out_word_t out_data
);
    import alm_pkg::*;

    state_t             state_reg, state_next;
    entry_t             tab_reg [TABLE_DEPTH];
    entry_t             tab_next [TABLE_DEPTH];
    q_head_t            cur_reg, cur_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               found_reg, found_next;
    logic [31:0]        now_reg, now_next;
    logic               sw_reg, sw_next;
    out_word_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               out_free;
    logic               m_any;
    logic [CNT_W-1:0]   m_pos;
    entry_t             e;
    entry_t             new_e;
    logic [7:0]         days_sh;
    logic               fire;
    logic               shift_en;
    logic [CNT_W-1:0]   shift_pos;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_slot;
    logic               mark_en;
    logic               emit;
    logic [2:0]         e_kind;
    logic [31:0]        e_id;
    logic [1:0]         e_act;
    logic               e_rem;

    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        m_any = 1'b0;
        m_pos = '0;
        for (int j = TABLE_DEPTH - 1; j >= 0; j--)
        begin
            if (CNT_W'(j) < cnt_reg && tab_reg[j].ident == cur_reg.word.alarm_id)
            begin
                m_any = 1'b1;
                m_pos = CNT_W'(j);
            end
        end
    end

    always_comb
    begin
        e = tab_reg[idx_reg[IDX_W-1:0]];
        days_sh = {1'b0, e.days} >> cur_reg.word.weekday;
        case (e.kind)
            TK_ONESHOT: fire = (e.tval == now_reg);
            TK_PERIODIC: fire = (32'(e.mark + e.tval) == now_reg);
            TK_WEEKLY: fire = (cur_reg.word.weekday < 3'd7) && days_sh[0] &&
                              (e.hour == cur_reg.word.hour) &&
                              (e.minute == cur_reg.word.minute) &&
                              (cur_reg.word.second == 6'd0);
            default: fire = 1'b0;
        endcase
    end

    always_comb
    begin
        new_e.ident = cur_reg.word.alarm_id;
        new_e.kind = cur_reg.word.timer_kind;
        new_e.action = cur_reg.word.action;
        new_e.tval = (cur_reg.word.timer_kind == TK_WEEKLY) ? 32'd0 : cur_reg.word.time_value;
        new_e.mark = (cur_reg.word.timer_kind == TK_PERIODIC) ? now_reg : 32'd0;
        new_e.days = (cur_reg.word.timer_kind == TK_WEEKLY) ? cur_reg.word.weekday_mask : 7'd0;
        new_e.hour = (cur_reg.word.timer_kind == TK_WEEKLY) ? cur_reg.word.hour : 5'd0;
        new_e.minute = (cur_reg.word.timer_kind == TK_WEEKLY) ? cur_reg.word.minute : 6'd0;
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        found_next = found_reg;
        now_next = now_reg;
        sw_next = sw_reg;
        pop = 1'b0;
        shift_en = 1'b0;
        shift_pos = idx_reg;
        wr_en = 1'b0;
        wr_slot = cnt_reg;
        mark_en = 1'b0;
        emit = 1'b0;
        e_kind = RK_DONE;
        e_id = cur_reg.word.alarm_id;
        e_act = 2'd0;
        e_rem = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    cur_next = head;
                    case (head.op)
                        OP_TICK:
                        begin
                            now_next = head.word.time_value;
                            idx_next = '0;
                            state_next = ST_WALK;
                        end
                        OP_INSERT, OP_DELETE: state_next = ST_FIND;
                        default: state_next = ST_EXEC;
                    endcase
                end
            end
            ST_FIND:
            begin
                found_next = m_any;
                pos_next = m_pos;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    state_next = ST_IDLE;
                    shift_pos = pos_reg;
                    case (cur_reg.op)
                        OP_DELETE:
                        begin
                            if (found_reg)
                            begin
                                shift_en = 1'b1;
                                cnt_next = cnt_reg - 1'b1;
                                e_kind = RK_DELETED;
                            end
                            else
                                e_kind = RK_NOT_FOUND;
                        end
                        OP_INSERT:
                        begin
                            if (cur_reg.word.timer_kind == TK_ONESHOT &&
                                cur_reg.word.time_value <= now_reg)
                                e_kind = RK_REJECTED;
                            else if (found_reg)
                            begin
                                shift_en = 1'b1;
                                wr_en = 1'b1;
                                wr_slot = cnt_reg - 1'b1;
                                e_kind = RK_INSERTED;
                            end
                            else if (cnt_reg == CNT_W'(TABLE_DEPTH))
                                e_kind = RK_FULL;
                            else
                            begin
                                wr_en = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                e_kind = RK_INSERTED;
                            end
                        end
                        default: e_kind = RK_REJECTED;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    if (idx_reg >= cnt_reg)
                    begin
                        emit = 1'b1;
                        e_kind = RK_DONE;
                        e_id = 32'd0;
                        state_next = ST_IDLE;
                    end
                    else if (fire)
                    begin
                        emit = 1'b1;
                        e_kind = RK_FIRED;
                        e_id = e.ident;
                        e_act = e.action;
                        sw_next = apply_act(sw_reg, e.action);
                        if (e.kind == TK_ONESHOT)
                        begin
                            shift_en = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                            e_rem = 1'b1;
                        end
                        else
                        begin
                            mark_en = (e.kind == TK_PERIODIC);
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
            tab_next[j] = tab_reg[j];
        for (int j = 0; j < TABLE_DEPTH - 1; j++)
        begin
            if (shift_en && CNT_W'(j) >= shift_pos && CNT_W'(j + 1) < cnt_reg)
                tab_next[j] = tab_reg[j + 1];
        end
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (wr_en && CNT_W'(j) == wr_slot)
                tab_next[j] = new_e;
            if (mark_en && CNT_W'(j) == idx_reg)
                tab_next[j].mark = now_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next.kind = e_kind;
            out_next.alarm_id_res = e_id;
            out_next.fired_action = e_act;
            out_next.removed = e_rem;
            out_next.switch_on = sw_next;
            out_next.pin_level = sw_next ~^ level;
            out_next.entry_count = 5'(cnt_next);
            out_next.last = (e_kind != RK_FIRED);
        end
    end

    always_ff @(posedge clk)
    begin
        tab_reg <= tab_next;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        found_reg <= found_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            now_reg <= 32'd0;
            sw_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            now_reg <= now_next;
            sw_reg <= sw_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/alarm_timer_table_engine.sv =====
// Alarm schedule table with a switch output.
// Input words (tick, insert, delete) enter on in_valid/in_ready and wait in a
// two-word queue, so the sender can push ahead while earlier words are worked.
// Result words leave on out_valid/out_ready; every input word gives one or more
// results, and the final one of a word has last set.
// An insert or delete word passes from the queue through the find and exec
// states before its result is registered; a word with a bad id, kind, mask or
// function skips the find state.
// A tick walks the table one entry per cycle while the receiver is ready, and its
// done result comes last, with any fired results before it.
// The back end takes the next queued word as soon as it finishes, so it handles
// one word at a time and takes no new word before the last one's result is
// registered; a tick holds it for the whole walk over the table registers.
// While the receiver stalls, the result register holds and the walk waits; the
// queue keeps accepting until it holds two words.
// The active level register sits at byte address 0 of the APB port.
// Reset empties the table, clears the timestamp, turns the switch off and sets
// the active level to one.
module alarm_timer_table_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  alm_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output alm_pkg::out_word_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import alm_pkg::*;

    q_head_t head;
    logic    pop;
    logic    level_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ACTIVE_LEVEL) ? {31'd0, level_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= 1'b1;
        else if (psel && penable && pwrite && pready && paddr == REG_ACTIVE_LEVEL)
            level_reg <= pwdata[0];
    end

    alm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    alm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .level     (level_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.entry_count <= 5'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.kind != RK_FIRED)))
        else $error("last flag does not match result kind");

    a_pin_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.pin_level == (out_data.switch_on ~^ level_reg))
        else $error("pin level does not follow active level");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

endmodule
